>>> hw/rtl/text_console_writer_macros.svh
// Assertion shorthands used by the console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TXC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("text console check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TXC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("text console check failed");

`endif

>>> hw/rtl/txc_pkg.sv
package txc_pkg;

    // Operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_HOME  = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Character and cell constants
    localparam logic [7:0]  NEWLINE_CODE   = 8'd10;
    localparam logic [7:0]  SPACE_CODE     = 8'h20;
    localparam logic [15:0] RESET_CELL     = 16'h0720;
    localparam logic [7:0]  BLANK_ATTR_RST = 8'h07;

    // Input word
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] char_code;
        logic [7:0] color;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } txc_in_t;

    // Result word
    typedef struct packed {
        logic [4:0]  cur_row;
        logic [6:0]  cur_col;
        logic [15:0] cell_data;
    } txc_out_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_SCROLL,
        ST_FILL,
        ST_PUT
    } txc_state_t;

endpackage

>>> hw/rtl/text_console_writer.sv
// Character-cell text console. The screen lives in one single-port-write,
// registered-read memory of ROWS*COLS cells; a sequencer drives its one write
// port. An ordinary character, a newline or home is done in the accept state; a cell
// read waits in ST_READ for the registered memory data; a clear is the accept, then
// one blank write per cell; and a character that lands on a pending scroll is the
// accept, copy of ROWS-1 lines, blank fill of the bottom line, then the store. After
// reset the memory is initialized one cell per cycle, and no input word is taken
// until that sweep ends; blank_attr writes are taken at any time.
// Results queue in a two-word output buffer, so a new word is accepted while a
// result still waits downstream.
`include "text_console_writer_macros.svh"

module text_console_writer #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  txc_pkg::txc_in_t in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output txc_pkg::txc_out_t out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [7:0]       cfg_data
);

    import txc_pkg::*;

    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int COL_W  = $clog2(COLS);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELLS - COLS);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLS);
    localparam logic [ROW_W-1:0]  ROWS_V    = ROW_W'(ROWS);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COL_W:0]    COLS_V    = (COL_W + 1)'(COLS);

    txc_state_t        state_reg;
    txc_state_t        state_next;
    logic [ADDR_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] cnt_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [7:0]        char_reg;
    logic [7:0]        char_next;
    logic [7:0]        color_reg;
    logic [7:0]        color_next;
    logic              rd_ok_reg;
    logic              rd_ok_next;
    logic [7:0]        blank_attr_reg;

    logic              in_accept;
    logic              read_accept;
    logic              room;
    logic              push;
    txc_out_t          push_data;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [15:0]       wdata;
    logic [ADDR_W-1:0] raddr;
    logic [15:0]       rdata;

    logic [7:0]        put_char;
    logic [7:0]        put_color;
    logic [ADDR_W-1:0] put_addr;
    logic [COL_W:0]    col_inc;
    logic [ROW_W-1:0]  put_row;
    logic [COL_W-1:0]  put_col;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_in_range;
    logic [15:0]       blank_cell;

    assign in_stall    = !((state_reg == ST_IDLE) && room);
    assign in_accept   = in_valid && !in_stall;
    assign read_accept = in_accept && (in_data.op == OP_READ);
    assign cfg_ready   = 1'b1;
    assign blank_cell  = {blank_attr_reg, SPACE_CODE};

    // Hold the blank attribute
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blank_attr_reg <= BLANK_ATTR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            blank_attr_reg <= cfg_data;
        end
    end

    // Store path: cell address at the cursor and cursor advance with wrap
    always_comb
    begin
        put_char  = (state_reg == ST_PUT) ? char_reg  : in_data.char_code;
        put_color = (state_reg == ST_PUT) ? color_reg : in_data.color;
        put_addr  = ADDR_W'(row_reg) * COLS_A + ADDR_W'(col_reg);
        col_inc   = {1'b0, col_reg} + (COL_W + 1)'(1);
        if (col_inc == COLS_V)
        begin
            put_col = '0;
            put_row = row_reg + ROW_W'(1);
        end
        else
        begin
            put_col = col_inc[COL_W-1:0];
            put_row = row_reg;
        end
    end

    // Read-back address and range check
    always_comb
    begin
        rd_addr     = ADDR_W'(in_data.read_row) * COLS_A + ADDR_W'(in_data.read_col);
        rd_in_range = (7'(in_data.read_row) < 7'(ROWS)) &&
                      (8'(in_data.read_col) < 8'(COLS));
    end

    // Sequencer: next state, memory port and result push
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        char_next  = char_reg;
        color_next = color_reg;
        rd_ok_next = rd_ok_reg;
        we         = 1'b0;
        waddr      = cnt_reg;
        wdata      = blank_cell;
        raddr      = cnt_reg + COLS_A;
        push       = 1'b0;
        push_data.cell_data = '0;

        case (state_reg)
            ST_INIT:
            begin
                we    = 1'b1;
                wdata = RESET_CELL;
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end

            ST_IDLE:
            begin
                raddr = rd_addr;
                if (in_accept)
                begin
                    case (in_data.op)
                        OP_WRITE:
                        begin
                            if (in_data.char_code == NEWLINE_CODE)
                            begin
                                if (row_reg < ROWS_V)
                                begin
                                    row_next = row_reg + ROW_W'(1);
                                end
                                col_next = '0;
                                push     = 1'b1;
                            end
                            else if (row_reg >= ROWS_V)
                            begin
                                char_next  = in_data.char_code;
                                color_next = in_data.color;
                                row_next   = LAST_ROW;
                                col_next   = '0;
                                cnt_next   = '0;
                                state_next = ST_SCROLL;
                            end
                            else
                            begin
                                we       = 1'b1;
                                waddr    = put_addr;
                                wdata    = {put_color, put_char};
                                row_next = put_row;
                                col_next = put_col;
                                push     = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        OP_HOME:
                        begin
                            row_next = '0;
                            col_next = '0;
                            push     = 1'b1;
                        end
                        OP_READ:
                        begin
                            rd_ok_next = rd_in_range;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                push                = 1'b1;
                push_data.cell_data = rd_ok_reg ? rdata : 16'h0000;
                state_next          = ST_IDLE;
            end

            ST_CLEAR:
            begin
                we = 1'b1;
                if (cnt_reg == LAST_ADDR)
                begin
                    row_next   = '0;
                    col_next   = '0;
                    cnt_next   = '0;
                    push       = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end

            ST_SCROLL:
            begin
                // read the cell one line below, write the one read last cycle
                if (cnt_reg != '0)
                begin
                    we    = 1'b1;
                    waddr = cnt_reg - ADDR_W'(1);
                    wdata = rdata;
                end
                if (cnt_reg == COPY_END)
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end

            ST_FILL:
            begin
                we = 1'b1;
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next   = '0;
                    state_next = ST_PUT;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end

            ST_PUT:
            begin
                we         = 1'b1;
                waddr      = put_addr;
                wdata      = {put_color, put_char};
                row_next   = put_row;
                col_next   = put_col;
                push       = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        push_data.cur_row = 5'(row_next);
        push_data.cur_col = 7'(col_next);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            cnt_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    // Pending character and read flag
    always_ff @(posedge clk)
    begin
        char_reg  <= char_next;
        color_reg <= color_next;
        rd_ok_reg <= rd_ok_next;
    end

    txc_screen_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_screen (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    txc_out_fifo u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    `TXC_ASSERT_IMP(a_push_has_room, clk, rst_n, push, room)
    `TXC_ASSERT_IMP(a_row_bounded, clk, rst_n, 1'b1, row_reg <= ROWS_V)
    `TXC_ASSERT_NXT(a_read_waits, clk, rst_n, read_accept, state_reg == ST_READ)
    `TXC_ASSERT_IMP(a_put_after_scroll, clk, rst_n, state_reg == ST_PUT, (row_reg == LAST_ROW) && (col_reg == '0))

endmodule

>>> hw/rtl/txc_screen_ram.sv
module txc_screen_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [15:0]       wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [15:0]       rdata
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;

    // Write one cell
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/txc_out_fifo.sv
module txc_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  txc_pkg::txc_out_t push_data,
    output logic              room,
    output logic              out_valid,
    input  logic              out_stall,
    output txc_pkg::txc_out_t out_data
);

    import txc_pkg::*;

    txc_out_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign room      = (count_reg != 2'd2);
    assign pop       = out_valid && !out_stall;
    assign out_data  = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold the queued words
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> dv/tb_top.sv
module tb_top;
    import txc_pkg::*;

    localparam int SCR_COLS    = 80;
    localparam int SCR_ROWS    = 25;
    localparam int SCR_CELLS   = SCR_COLS * SCR_ROWS;
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int TAIL_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 25;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    txc_in_t    in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    txc_out_t   out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = '0;

    // Shadow copy of the console: screen, cursor and blank attribute
    logic [15:0] shadow_screen [SCR_CELLS];
    int unsigned shadow_row;
    int unsigned shadow_col;
    logic [7:0]  shadow_blank_attr;

    // Cursor/readback words still owed by the console, oldest first
    txc_out_t cursor_readback_q [$];

    int n_words          = 0;
    int n_results        = 0;
    int n_scrolls        = 0;
    int n_clears         = 0;
    int n_reads          = 0;
    int n_offscreen_read = 0;
    int n_cfg_writes     = 0;
    int n_mismatch       = 0;
    int burst_left       = 0;
    bit no_gaps          = 1'b0;
    int hold_req         = 0;
    int longest_hold     = 0;
    int cycle_count      = 0;

    text_console_writer #(
        .COLS(SCR_COLS),
        .ROWS(SCR_ROWS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin : clock_gen
        forever #5 clk = ~clk;
    end

    function automatic void reset_shadow();
        foreach (shadow_screen[i])
        begin
            shadow_screen[i] = RESET_CELL;
        end
        shadow_row        = 0;
        shadow_col        = 0;
        shadow_blank_attr = BLANK_ATTR_RST;
    endfunction

    // Apply one word to the shadow console and return the cursor/readback it yields
    function automatic txc_out_t predict_console(input txc_in_t w);
        txc_out_t    view;
        logic [15:0] blank;
        int          i;
        view  = '0;
        blank = {shadow_blank_attr, SPACE_CODE};
        case (w.op)
            OP_WRITE:
            begin
                if (w.char_code == NEWLINE_CODE)
                begin
                    // newline saturates at the pending-scroll row
                    if (shadow_row < SCR_ROWS)
                        shadow_row++;
                    shadow_col = 0;
                end
                else
                begin
                    if (shadow_row >= SCR_ROWS)
                    begin
                        // scroll: shift lines up, blank the bottom line
                        for (i = 0; i < SCR_CELLS - SCR_COLS; i++)
                            shadow_screen[i] = shadow_screen[i + SCR_COLS];
                        for (i = SCR_CELLS - SCR_COLS; i < SCR_CELLS; i++)
                            shadow_screen[i] = blank;
                        shadow_row = SCR_ROWS - 1;
                        shadow_col = 0;
                        n_scrolls++;
                    end
                    shadow_screen[shadow_row * SCR_COLS + shadow_col] = {w.color, w.char_code};
                    shadow_col++;
                    if (shadow_col >= SCR_COLS)
                    begin
                        shadow_col = 0;
                        if (shadow_row < SCR_ROWS)
                            shadow_row++;
                    end
                end
            end
            OP_CLEAR:
            begin
                for (i = 0; i < SCR_CELLS; i++)
                    shadow_screen[i] = blank;
                shadow_row = 0;
                shadow_col = 0;
                n_clears++;
            end
            OP_HOME:
            begin
                shadow_row = 0;
                shadow_col = 0;
            end
            OP_READ:
            begin
                n_reads++;
                if (w.read_row < SCR_ROWS && w.read_col < SCR_COLS)
                    view.cell_data = shadow_screen[w.read_row * SCR_COLS + w.read_col];
                else
                    n_offscreen_read++;
            end
        endcase
        view.cur_row = 5'(shadow_row);
        view.cur_col = 7'(shadow_col);
        return view;
    endfunction

    // Word builders: fields that the operation ignores carry random bits
    function automatic txc_in_t char_word(input logic [7:0] ch, input logic [7:0] attr);
        txc_in_t w;
        w           = txc_in_t'(30'($urandom));
        w.op        = OP_WRITE;
        w.char_code = ch;
        w.color     = attr;
        return w;
    endfunction

    function automatic txc_in_t read_word(input int unsigned r, input int unsigned c);
        txc_in_t w;
        w          = txc_in_t'(30'($urandom));
        w.op       = OP_READ;
        w.read_row = 5'(r);
        w.read_col = 7'(c);
        return w;
    endfunction

    function automatic txc_in_t ctl_word(input logic [1:0] op);
        txc_in_t w;
        w    = txc_in_t'(30'($urandom));
        w.op = op;
        return w;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_glyph();
        return 8'($urandom_range(32, 126));
    endfunction

    task automatic report_mismatch(input string field, input int unsigned want,
                                   input int unsigned got);
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
    endtask

    // Offer one word in bursts with random gaps; record its prediction on acceptance
    task automatic send_word(input txc_in_t w);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (no_gaps || $urandom_range(0, 9) < 3)
                gap = 0;
            else if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(9, 40);
            else
                gap = $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (in_stall !== 1'b0);
        cursor_readback_q.push_back(predict_console(w));
        n_words++;
    endtask

    // Drop valid and hold until every owed result has come back
    task automatic wait_results_done();
        in_valid <= 1'b0;
        do @(posedge clk); while (cursor_readback_q.size() != 0);
    endtask

    task automatic set_blank_attr(input logic [7:0] attr);
        cfg_valid <= 1'b1;
        cfg_data  <= attr;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        shadow_blank_attr = attr;
        n_cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        // power-on screen: corners and off-screen reads
        send_word(read_word(0, 0));
        send_word(read_word(SCR_ROWS - 1, SCR_COLS - 1));
        send_word(read_word(SCR_ROWS, 0));
        send_word(read_word(0, SCR_COLS));
        send_word(read_word(31, 127));
        // extreme characters and colors, newline mid-line
        send_word(char_word(8'h00, 8'h00));
        send_word(char_word(8'hFF, 8'hFF));
        send_word(char_word(8'h41, 8'h1E));
        send_word(char_word(NEWLINE_CODE, 8'hFF));
        send_word(char_word(8'h7F, 8'h80));
        send_word(char_word(8'h80, 8'h7F));
        send_word(read_word(0, 0));
        send_word(read_word(0, 1));
        send_word(read_word(0, 2));
        send_word(read_word(1, 0));
        send_word(read_word(1, 1));
        // home and overwrite the first cell
        send_word(ctl_word(OP_HOME));
        send_word(char_word(8'h5A, 8'hA5));
        send_word(read_word(0, 0));
        send_word(char_word(NEWLINE_CODE, 8'h00));
        // clear with the power-on blank attribute
        send_word(ctl_word(OP_CLEAR));
        send_word(read_word(1, 0));
        send_word(read_word(SCR_ROWS - 1, SCR_COLS - 1));
        wait_results_done();
    endtask

    task automatic test_scroll_edges();
        int i;
        send_word(ctl_word(OP_HOME));
        for (i = 0; i < SCR_ROWS; i++)
            send_word(char_word(NEWLINE_CODE, rand_byte()));
        // newline while a scroll is pending, then a character that scrolls
        send_word(char_word(NEWLINE_CODE, rand_byte()));
        send_word(char_word(8'h21, 8'h4F));
        send_word(read_word(SCR_ROWS - 1, 0));
        send_word(read_word(SCR_ROWS - 1, 1));
        send_word(read_word(SCR_ROWS - 2, 0));
        // fill the bottom line so the cursor wraps into a pending scroll
        for (i = 1; i < SCR_COLS; i++)
            send_word(char_word(rand_glyph(), rand_byte()));
        send_word(char_word(8'h7E, 8'h0C));
        send_word(read_word(SCR_ROWS - 2, SCR_COLS - 1));
        send_word(read_word(SCR_ROWS - 1, 0));
        send_word(read_word(SCR_ROWS - 1, SCR_COLS - 1));
        wait_results_done();
    endtask

    task automatic test_blank_attr_sweep();
        logic [7:0] attrs [4];
        attrs = '{8'h00, 8'hFF, rand_byte(), BLANK_ATTR_RST};
        foreach (attrs[k])
        begin
            wait_results_done();
            set_blank_attr(attrs[k]);
            send_word(ctl_word(OP_CLEAR));
            send_word(read_word($urandom_range(0, SCR_ROWS - 1),
                                $urandom_range(0, SCR_COLS - 1)));
            while (shadow_row < SCR_ROWS)
                send_word(char_word(NEWLINE_CODE, rand_byte()));
            send_word(char_word(rand_glyph(), rand_byte()));
            send_word(read_word(SCR_ROWS - 1, $urandom_range(1, SCR_COLS - 1)));
        end
        wait_results_done();
    endtask

    task automatic test_back_pressure();
        int i;
        wait_results_done();
        // receiver holds off while the sender keeps offering words
        no_gaps  = 1'b1;
        hold_req = HOLD_CYCLES;
        for (i = 0; i < 32; i++)
        begin
            if (i % 4 == 3)
                send_word(read_word($urandom_range(0, SCR_ROWS - 1),
                                    $urandom_range(0, SCR_COLS - 1)));
            else
                send_word(char_word(rand_glyph(), rand_byte()));
        end
        no_gaps = 1'b0;
        wait_results_done();
    endtask

    task automatic test_random_traffic(input int n_target);
        int first;
        int len;
        int pick;
        int k;
        first = n_words;
        while (n_words - first < n_target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                // line of text, sometimes longer than a row so it wraps
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(1, 40);
                for (k = 0; k < len; k++)
                    send_word(char_word(rand_byte(), rand_byte()));
                if ($urandom_range(0, 1) == 1)
                    send_word(char_word(NEWLINE_CODE, rand_byte()));
            end
            else if (pick < 50)
            begin
                // newline run, often long enough to reach a pending scroll
                len = $urandom_range(1, 30);
                for (k = 0; k < len; k++)
                    send_word(char_word(NEWLINE_CODE, rand_byte()));
            end
            else if (pick < 75)
            begin
                // read back on the cursor row or anywhere on screen, sometimes anywhere in the field range
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 4) == 0)
                        send_word(read_word($urandom_range(0, 31), $urandom_range(0, 127)));
                    else if ($urandom_range(0, 1) == 1)
                        send_word(read_word(shadow_row, $urandom_range(0, SCR_COLS - 1)));
                    else
                        send_word(read_word($urandom_range(0, SCR_ROWS - 1),
                                            $urandom_range(0, SCR_COLS - 1)));
                end
            end
            else if (pick < 85)
            begin
                // drive to a pending scroll, then land characters on it
                while (shadow_row < SCR_ROWS)
                    send_word(char_word(NEWLINE_CODE, rand_byte()));
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++)
                    send_word(char_word(rand_glyph(), rand_byte()));
                send_word(read_word(SCR_ROWS - 1, $urandom_range(0, SCR_COLS - 1)));
            end
            else if (pick < 93)
                send_word(txc_in_t'(30'($urandom)));
            else if (pick < 97)
                send_word(ctl_word(OP_HOME));
            else
                send_word(ctl_word(OP_CLEAR));
        end
    endtask

    // Compare each accepted result with the oldest prediction
    initial
    begin : result_checker
        txc_out_t want;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (cursor_readback_q.size() == 0)
                    report_mismatch("unexpected result", 0, 32'(out_data));
                else
                begin
                    want = cursor_readback_q.pop_front();
                    n_results++;
                    if (out_data.cur_row !== want.cur_row)
                        report_mismatch("cur_row", 32'(want.cur_row),
                                        32'(out_data.cur_row));
                    if (out_data.cur_col !== want.cur_col)
                        report_mismatch("cur_col", 32'(want.cur_col),
                                        32'(out_data.cur_col));
                    if (out_data.cell_data !== want.cell_data)
                        report_mismatch("cell_data", 32'(want.cell_data),
                                        32'(out_data.cell_data));
                end
            end
        end
    end

    // Receiver stall pattern, plus a counted hold-off on request
    initial
    begin : rx_stall_gen
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        mode      = RX_FREE;
        mode_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                if (hold_req > longest_hold)
                    longest_hold = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 160);
                end
                mode_left--;
                case (mode)
                    RX_FREE:     out_stall <= 1'b0;
                    RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: out_stall <= ((cycle_count % 7) < 3);
                endcase
            end
        end
    end

    // Cycle budget
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: cycle limit reached with %0d results outstanding",
                 $time, cursor_readback_q.size());
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int phase;
        reset_shadow();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_scroll_edges();
        test_blank_attr_sweep();
        test_back_pressure();
        for (phase = 0; phase < 4; phase++)
        begin
            wait_results_done();
            set_blank_attr(rand_byte());
            test_random_traffic(100);
        end

        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (cursor_readback_q.size() != 0)
            report_mismatch("results left owed", 0, 32'(cursor_readback_q.size()));

        $display("Covered %0d words and %0d results: %0d scrolls, %0d clears, %0d reads",
                 n_words, n_results, n_scrolls, n_clears, n_reads);
        $display("(%0d off-screen), blank attribute written %0d times, longest hold-off %0d",
                 n_offscreen_read, n_cfg_writes, longest_hold);
        if (n_mismatch == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
